// ===== src/srg_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// Step generator package
// Shared constants, register codes, state encoding and unit handshake types
// for the stepper velocity ramp step generator.
// ============================================================================
package srg_pkg;

    // Default build parameters.
    localparam int TIME_BITS_DEF = 48;
    localparam int FRAC_BITS_DEF = 8;

    // Field and register widths.
    localparam int CFG_W     = 24;
    localparam int CFG_IDX_W = 2;
    localparam int SPEED_W   = 24;
    localparam int DIRCMD_W  = 2;
    localparam int VEL_W     = 25;
    localparam int INTV_W    = 24;
    localparam int RAMP_W    = 27;   // ramp increment, saturates at 2**26

    // Time constants in microseconds.
    localparam int US_BITS = 20;
    localparam logic [US_BITS-1:0] US_PER_S      = 20'd1000000;
    localparam logic [INTV_W-1:0]  SLOW_INTERVAL = 24'd10000000;

    // Shared serial divider geometry. Dividends sit left-aligned in the
    // dividend register; the ramp dividend never exceeds 2**26 * 1e6.
    localparam int DIVIDEND_W = 46;
    localparam int DIVISOR_W  = 25;
    localparam int QUOT_W     = 26;
    localparam int DIV_CNT_W  = 6;
    localparam logic [DIVIDEND_W-1:0] RAMP_LIMIT = 46'd67108864000000;
    localparam logic [RAMP_W-1:0]     RAMP_CAP   = 27'd67108864;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TARGET_SPEED = 2'd0,
        REG_ACCEL        = 2'd1,
        REG_DIRECTION    = 2'd2,
        REG_JERK_BAND    = 2'd3
    } srg_reg_idx_t;

    // Direction command codes; both patterns with the sign bit set mean reverse.
    localparam logic [DIRCMD_W-1:0] DIR_STOP    = 2'b00;
    localparam logic [DIRCMD_W-1:0] DIR_FORWARD = 2'b01;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV_RAMP,
        ST_UPDATE,
        ST_INTERVAL,
        ST_DIV_INTV,
        ST_FINISH
    } srg_state_t;

    // Status reported by a serial arithmetic unit.
    typedef struct packed {
        logic busy;
        logic done;
    } srg_unit_status_t;

    // Command to the serial divider.
    typedef struct packed {
        logic                 start;
        logic [DIV_CNT_W-1:0] count;
    } srg_div_cmd_t;

endpackage
`default_nettype wire

// ===== src/srg_serial_mul.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// Serial shift-add multiplier
// Multiplies an unsigned A by an unsigned B, one bit of A per cycle, LSB first.
// ============================================================================
module srg_serial_mul
    import srg_pkg::*;
#(
    parameter int A_W = SPEED_W,
    parameter int B_W = TIME_BITS_DEF
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 start,
    input  wire logic [A_W-1:0]       a,
    input  wire logic [B_W-1:0]       b,
    output srg_unit_status_t          status,
    output logic      [A_W+B_W-1:0]   product
);

    localparam int PW    = A_W + B_W;
    localparam int CNT_W = $clog2(A_W + 1);

    logic [PW-1:0]    prod_reg,  prod_next;
    logic [B_W-1:0]   mcand_reg, mcand_next;
    logic [CNT_W-1:0] cnt_reg,   cnt_next;
    logic             busy_reg,  busy_next;
    logic             done_reg,  done_next;
    logic [B_W:0]     sum;

    // Partial sum: upper product half plus the multiplicand when the current bit is set.
    assign sum = {1'b0, prod_reg[PW-1:A_W]} + {1'b0, (prod_reg[0] ? mcand_reg : {B_W{1'b0}})};

    always_comb begin
        prod_next  = prod_reg;
        mcand_next = mcand_reg;
        cnt_next   = cnt_reg;
        busy_next  = busy_reg;
        done_next  = 1'b0;
        if (start) begin
            prod_next  = {{B_W{1'b0}}, a};
            mcand_next = b;
            cnt_next   = CNT_W'(A_W);
            busy_next  = 1'b1;
        end else if (busy_reg) begin
            prod_next = {sum, prod_reg[A_W-1:1]};
            cnt_next  = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control state is reset; the datapath is not.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        prod_reg  <= prod_next;
        mcand_reg <= mcand_next;
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign product     = prod_reg;

endmodule
`default_nettype wire

// ===== src/srg_serial_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// Serial restoring divider
// Produces one quotient bit per cycle from a left-aligned dividend.
// ============================================================================
module srg_serial_div
    import srg_pkg::*;
#(
    parameter int N_W = DIVIDEND_W,
    parameter int D_W = DIVISOR_W,
    parameter int Q_W = QUOT_W
) (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire srg_div_cmd_t    cmd,
    input  wire logic [N_W-1:0]  dividend,
    input  wire logic [D_W-1:0]  divisor,
    output srg_unit_status_t     status,
    output logic      [Q_W-1:0]  quotient
);

    logic [N_W-1:0]       num_reg,  num_next;
    logic [D_W-1:0]       dsr_reg,  dsr_next;
    logic [D_W-1:0]       rem_reg,  rem_next;
    logic [Q_W-1:0]       quot_reg, quot_next;
    logic [DIV_CNT_W-1:0] cnt_reg,  cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [D_W:0]         shifted;
    logic [D_W:0]         trial;
    logic                 fits;

    // One restoring step: bring down the next dividend bit and try a subtract.
    assign shifted = {rem_reg, num_reg[N_W-1]};
    assign trial   = shifted - {1'b0, dsr_reg};
    assign fits    = (shifted >= {1'b0, dsr_reg});

    always_comb begin
        num_next  = num_reg;
        dsr_next  = dsr_reg;
        rem_next  = rem_reg;
        quot_next = quot_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (cmd.start) begin
            num_next  = dividend;
            dsr_next  = divisor;
            rem_next  = '0;
            quot_next = '0;
            cnt_next  = cmd.count;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            num_next  = {num_reg[N_W-2:0], 1'b0};
            rem_next  = fits ? trial[D_W-1:0] : shifted[D_W-1:0];
            quot_next = {quot_reg[Q_W-2:0], fits};
            cnt_next  = cnt_reg - 1'b1;
            if (cnt_reg == DIV_CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        num_reg  <= num_next;
        dsr_reg  <= dsr_next;
        rem_reg  <= rem_next;
        quot_reg <= quot_next;
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign quotient    = quot_reg;

endmodule
`default_nettype wire

// ===== src/stepper_velocity_ramp_step_generator_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Each wake event runs through the serial multiplier and then the shared serial divider
// (ramp, then interval), both one bit per cycle; a division is skipped when the ramp
// increment saturates or the speed is slow. A new wake event is accepted only once the
// sequencer has returned to idle, after the previous result has been loaded.
// Reset (aresetn low, synchronous) clears velocity and configuration, sets the
// next step time to 10000000 us and the awake pin high.
// ============================================================================
// Stepper velocity ramp step generator
// Handles wake events: step and pin decisions, trapezoidal ramp and the
// scheduling of the next step from the step interval.
// ============================================================================
module stepper_velocity_ramp_step_generator_unit
    import srg_pkg::*;
#(
    parameter int TIME_BITS = TIME_BITS_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    localparam int IN_W     = ((TIME_BITS + 7) / 8) * 8,
    localparam int OUT_BITS = 4 + TIME_BITS + INTV_W + VEL_W,
    localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    // Wake event channel.
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [IN_W-1:0]      s_tdata,   // now_us
    // Result channel.
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    // stepped, step_level, dir_level, awake_level, next_step_time_us,
    // interval_us, velocity_out_q8
    output logic      [OUT_W-1:0]     m_tdata,
    // Configuration write port.
    input  wire logic                 cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_wdata
);

    localparam int PROD_W = SPEED_W + TIME_BITS;
    localparam logic [DIV_CNT_W-1:0]  RAMP_COUNT    = DIV_CNT_W'(DIVIDEND_W);
    localparam logic [DIV_CNT_W-1:0]  INTV_COUNT    = DIV_CNT_W'(US_BITS + FRAC_BITS);
    localparam logic [DIVIDEND_W-1:0] INTV_DIVIDEND =
        {US_PER_S, {(DIVIDEND_W - US_BITS){1'b0}}};
    localparam logic [28:0] SLOW_LIMIT = 29'(64'd1 << FRAC_BITS);

    // Configuration registers.
    logic [SPEED_W-1:0]  target_speed_reg;
    logic [SPEED_W-1:0]  accel_reg;
    logic [DIRCMD_W-1:0] direction_reg;
    logic [SPEED_W-1:0]  jerk_band_reg;

    // Sequencer and motion state.
    srg_state_t              state_reg, state_next;
    logic signed [VEL_W-1:0] velocity_reg, velocity_next;
    logic [TIME_BITS-1:0]    last_step_reg, next_step_reg;
    logic                    step_pin_reg, dir_pin_reg, awake_pin_reg;
    logic                    stepped_reg;
    logic [RAMP_W-1:0]       ramp_reg;
    logic [INTV_W-1:0]       interval_reg;
    logic                    m_valid_reg;
    logic [OUT_W-1:0]        m_data_reg;

    // Handshakes and control strobes.
    logic s_accept;
    logic out_free;
    logic mul_start;
    logic ramp_sat;
    logic slow;
    logic ramp_load_sat, ramp_load_div;
    logic intv_load_slow, intv_load_div;
    logic vel_load;
    logic out_load;

    // Arithmetic units.
    srg_unit_status_t        mul_status, div_status;
    srg_div_cmd_t            div_cmd;
    logic [PROD_W-1:0]       mul_product;
    logic [TIME_BITS-1:0]    now_us;
    logic [TIME_BITS-1:0]    dt;
    logic [DIVIDEND_W-1:0]   div_dividend;
    logic [DIVISOR_W-1:0]    div_divisor;
    logic [QUOT_W-1:0]       div_quotient;
    logic                    step_hit;
    logic                    sleep;

    assign now_us   = s_tdata[TIME_BITS-1:0];
    assign s_accept = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;
    assign dt       = now_us - last_step_reg;
    assign step_hit = (now_us >= next_step_reg);
    assign sleep    = (direction_reg == DIR_STOP) && (velocity_reg == '0);

    // Ramp increment saturates once accel * dt reaches 2**26 * 1e6.
    assign ramp_sat = (|mul_product[PROD_W-1:DIVIDEND_W]) ||
                      (mul_product[DIVIDEND_W-1:0] >= RAMP_LIMIT);

    // Configuration writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            target_speed_reg <= '0;
            accel_reg        <= '0;
            direction_reg    <= '0;
            jerk_band_reg    <= '0;
        end else if (cfg_wr_en) begin
            unique case (srg_reg_idx_t'(cfg_index))
                REG_TARGET_SPEED: target_speed_reg <= cfg_wdata[SPEED_W-1:0];
                REG_ACCEL:        accel_reg        <= cfg_wdata[SPEED_W-1:0];
                REG_DIRECTION:    direction_reg    <= cfg_wdata[DIRCMD_W-1:0];
                REG_JERK_BAND:    jerk_band_reg    <= cfg_wdata[SPEED_W-1:0];
                default: ;
            endcase
        end
    end

    // Velocity update toward the target, in a 28-bit signed workspace.
    logic signed [27:0] v_ext, tgt_ext, ds_ext, err, err_abs, v_dn, v_up, v_new;

    always_comb begin
        unique case (direction_reg)
            DIR_STOP:    tgt_ext = '0;
            DIR_FORWARD: tgt_ext = signed'({4'b0, target_speed_reg});
            default:     tgt_ext = -signed'({4'b0, target_speed_reg});
        endcase
        v_ext   = 28'(velocity_reg);
        ds_ext  = signed'({1'b0, ramp_reg});
        err     = v_ext - tgt_ext;
        err_abs = (err < 0) ? -err : err;
        v_dn    = v_ext - ds_ext;
        v_up    = v_ext + ds_ext;
        if (err_abs < signed'({4'b0, jerk_band_reg})) begin
            v_new = tgt_ext;
        end else if (v_ext > tgt_ext) begin
            v_new = (v_dn < tgt_ext) ? tgt_ext : v_dn;
        end else if (v_ext < tgt_ext) begin
            v_new = (v_up > tgt_ext) ? tgt_ext : v_up;
        end else begin
            v_new = v_ext;
        end
        velocity_next = v_new[VEL_W-1:0];
    end

    // Speed magnitude and the slow-speed test (|v| * 10 below one step/s).
    logic [DIVISOR_W-1:0] mag;
    logic [28:0]          mag_x10;

    assign mag     = velocity_reg[VEL_W-1] ? DIVISOR_W'(-velocity_reg) : DIVISOR_W'(velocity_reg);
    assign mag_x10 = ({4'b0, mag} << 3) + ({4'b0, mag} << 1);
    assign slow    = (mag_x10 < SLOW_LIMIT);

    // Next step time, saturating at the top of the time range.
    logic [TIME_BITS:0]   next_sum;
    logic [TIME_BITS-1:0] next_time;

    assign next_sum  = {1'b0, last_step_reg} + (TIME_BITS+1)'(interval_reg);
    assign next_time = next_sum[TIME_BITS] ? {TIME_BITS{1'b1}} : next_sum[TIME_BITS-1:0];

    // Sequencer: next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:     if (s_accept) state_next = ST_MUL;
            ST_MUL:      if (mul_status.done) state_next = ramp_sat ? ST_UPDATE : ST_DIV_RAMP;
            ST_DIV_RAMP: if (div_status.done) state_next = ST_UPDATE;
            ST_UPDATE:   state_next = ST_INTERVAL;
            ST_INTERVAL: state_next = slow ? ST_FINISH : ST_DIV_INTV;
            ST_DIV_INTV: if (div_status.done) state_next = ST_FINISH;
            ST_FINISH:   if (out_free) state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    // Sequencer: outputs and strobes.
    always_comb begin
        s_tready       = 1'b0;
        mul_start      = 1'b0;
        div_cmd.start  = 1'b0;
        div_cmd.count  = INTV_COUNT;
        div_dividend   = INTV_DIVIDEND;
        div_divisor    = mag;
        ramp_load_sat  = 1'b0;
        ramp_load_div  = 1'b0;
        vel_load       = 1'b0;
        intv_load_slow = 1'b0;
        intv_load_div  = 1'b0;
        out_load       = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready  = 1'b1;
                mul_start = s_tvalid;
            end
            ST_MUL: begin
                div_cmd.count = RAMP_COUNT;
                div_dividend  = mul_product[DIVIDEND_W-1:0];
                div_divisor   = DIVISOR_W'(US_PER_S);
                if (mul_status.done) begin
                    ramp_load_sat = ramp_sat;
                    div_cmd.start = !ramp_sat;
                end
            end
            ST_DIV_RAMP: ramp_load_div = div_status.done;
            ST_UPDATE:   vel_load = 1'b1;
            ST_INTERVAL: begin
                intv_load_slow = slow;
                div_cmd.start  = !slow;
            end
            ST_DIV_INTV: intv_load_div = div_status.done;
            ST_FINISH:   out_load = out_free;
            default: ;
        endcase
    end

    // Sequencer, motion state and result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            velocity_reg  <= '0;
            last_step_reg <= '0;
            next_step_reg <= TIME_BITS'(SLOW_INTERVAL);
            step_pin_reg  <= 1'b0;
            dir_pin_reg   <= 1'b0;
            awake_pin_reg <= 1'b1;
            stepped_reg   <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            // Step event: the direction pin updates together with a toggle of the awake or step pin.
            if (s_accept) begin
                stepped_reg <= step_hit;
                if (step_hit) begin
                    last_step_reg <= now_us;
                    dir_pin_reg   <= !velocity_reg[VEL_W-1] && (velocity_reg != '0);
                    if (awake_pin_reg == sleep) begin
                        awake_pin_reg <= !awake_pin_reg;
                    end else begin
                        step_pin_reg <= !step_pin_reg;
                    end
                end
            end
            if (vel_load) begin
                velocity_reg <= velocity_next;
            end
            if (out_load) begin
                next_step_reg <= next_time;
                m_valid_reg   <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers without reset.
    always_ff @(posedge aclk) begin
        if (ramp_load_sat) begin
            ramp_reg <= RAMP_CAP;
        end else if (ramp_load_div) begin
            ramp_reg <= RAMP_W'(div_quotient);
        end
        if (intv_load_slow) begin
            interval_reg <= SLOW_INTERVAL;
        end else if (intv_load_div) begin
            interval_reg <= div_quotient[INTV_W-1:0];
        end
        if (out_load) begin
            m_data_reg <= OUT_W'({velocity_reg, interval_reg, next_time,
                                  awake_pin_reg, dir_pin_reg, step_pin_reg, stepped_reg});
        end
    end

    // Arithmetic units.
    srg_serial_mul #(
        .A_W (SPEED_W),
        .B_W (TIME_BITS)
    ) u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .a       (accel_reg),
        .b       (dt),
        .status  (mul_status),
        .product (mul_product)
    );

    srg_serial_div #(
        .N_W (DIVIDEND_W),
        .D_W (DIVISOR_W),
        .Q_W (QUOT_W)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (div_cmd),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .status   (div_status),
        .quotient (div_quotient)
    );

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule
`default_nettype wire

// ===== src/srg_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// Step generator port checker
// Watches the ports of the step generator over time; bound to the top level.
// ============================================================================
module srg_checker
    import srg_pkg::*;
#(
    parameter int TIME_BITS = TIME_BITS_DEF,
    localparam int OUT_BITS = 4 + TIME_BITS + INTV_W + VEL_W,
    localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8,
    localparam int INTV_LSB = 4 + TIME_BITS
) (
    input wire logic                 aclk,
    input wire logic                 aresetn,
    input wire logic                 s_tvalid,
    input wire logic                 s_tready,
    input wire logic                 m_tvalid,
    input wire logic                 m_tready,
    input wire logic [OUT_W-1:0]     m_tdata
);

    // One wake event at a time: ready drops right after a transaction.
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted while a wake event is still in work");

    // A stalled result keeps its valid and its data.
    a_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed or vanished while stalled");

    // The step interval never exceeds the slow-speed interval.
    a_interval_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[INTV_LSB +: INTV_W] <= SLOW_INTERVAL)
        else $error("step interval out of range");

    // No result is presented in the cycle after reset.
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind stepper_velocity_ramp_step_generator_unit srg_checker #(
    .TIME_BITS (TIME_BITS)
) u_srg_checker (.*);
`default_nettype wire
